>>> src/batched_broadcast_matmul_macros.svh
// assertion macros for the batched broadcast matmul block
// no dependencies; included by the controller and the datapath
`ifndef BATCHED_BROADCAST_MATMUL_MACROS_SVH
`define BATCHED_BROADCAST_MATMUL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BBM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define BBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BBM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/bbm_pkg.sv
// shared constants, codes and controller/datapath structs of the batched matmul
// no dependencies
package bbm_pkg;

   localparam int MAX_MATRIX_SIDE = 16;
   localparam int MAX_BATCH       = 4;
   localparam int BATCH_DIMS      = 2;

   localparam int IDX_W   = 12;
   localparam int VAL_W   = 32;
   localparam int KIND_W  = 2;
   localparam int STS_W   = 2;
   localparam int BATCH_W = 3;
   localparam int SIDE_W  = 5;
   localparam int CSR_W   = 3;
   localparam int STORE_DEPTH = 1 << IDX_W;
   localparam int POS_W   = $clog2(MAX_MATRIX_SIDE);
   localparam int COORD_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int CNT_W   = $clog2((MAX_MATRIX_SIDE > IDX_W) ? MAX_MATRIX_SIDE : IDX_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(IDX_W - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE_A = 2'd0,
      KIND_WRITE_B = 2'd1,
      KIND_COMPUTE = 2'd2
   } kind_type;

   typedef enum logic [STS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_BATCH    = 2'd1,
      STATUS_OUT_OF_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_A_OUTER = 3'd0,
      CSR_A_INNER = 3'd1,
      CSR_B_OUTER = 3'd2,
      CSR_B_INNER = 3'd3,
      CSR_ROWS_M  = 3'd4,
      CSR_INNER_K = 3'd5,
      CSR_COLS_N  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_COL   = 2'd0,
      DIV_ROW   = 2'd1,
      DIV_BATCH = 2'd2
   } div_phase_type;

   typedef struct packed {
      logic          accept;
      logic          prep;
      logic          check;
      logic          div_init;
      logic          div_step;
      logic          div_capture;
      div_phase_type div_phase;
      logic          adr0;
      logic          adr1;
      logic          adr2;
      logic          mac_issue;
      logic          rsp_load;
   } bbm_cmd_type;

   typedef struct packed {
      logic             bad_batch;
      logic             out_of_range;
      logic [CNT_W-1:0] k_last;
      logic             pipe_busy;
      logic             out_full;
   } bbm_sts_type;

endpackage

>>> src/bbm_req_if.sv
// request channel: valid/ready handshake with kind, element index and write value
// depends on bbm_pkg
interface bbm_req_if import bbm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [IDX_W-1:0]        element_index;
   logic signed [VAL_W-1:0] write_value;

   modport source (output valid, output kind, output element_index, output write_value,
                   input ready);
   modport sink   (input valid, input kind, input element_index, input write_value,
                   output ready);
endinterface

>>> src/bbm_rsp_if.sv
// response channel: valid/ready handshake with product value and status
// depends on bbm_pkg
interface bbm_rsp_if import bbm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] product_value;
   logic [STS_W-1:0]        status;

   modport source (output valid, output product_value, output status, input ready);
   modport sink   (input valid, input product_value, input status, output ready);
endinterface

>>> src/batched_broadcast_matmul.sv
// top level of the batched broadcast matrix multiply
// depends on bbm_pkg, bbm_req_if, bbm_rsp_if, bbm_ctrl and bbm_datapath
//
// usage:
// req_chan carries one transaction per valid/ready edge. kind write A or write B
// stores write_value at element_index of that matrix store; writes can follow
// each other every cycle while the block is idle. kind compute asks for one
// element of the broadcast output; kind 3 is dropped. a compute transaction
// gives one rsp_chan transaction: the K-term dot product wrapped to 32 bits and
// a status. a good item runs three divider passes of 12 steps each to split the
// index, the address states ADR0 to ADR2, K store reads and a 3-stage
// multiply-accumulate pipeline; a failed batch check or range check skips these
// and answers with value 0. compute items are handled one at a time. the result
// sits in an output register: while rsp_chan stalls the block keeps taking
// requests and only holds at the point where it would load a second result.
// csr_* writes the seven shape registers; the user must write them only while
// the block is idle, as the block does not enforce it. reset (synchronous)
// returns the shape registers to 1 and empties the output; the stores are not
// cleared and must be written before they are read.
module batched_broadcast_matmul import bbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bbm_req_if.sink           req_chan,
   bbm_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [SIDE_W-1:0] csr_wdata
);

   bbm_cmd_type cmd;
   bbm_sts_type sts;

   bbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_kind    (req_chan.kind),
      .req_index   (req_chan.element_index),
      .req_value   (req_chan.write_value),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_product (rsp_chan.product_value),
      .rsp_status  (rsp_chan.status)
   );

endmodule

>>> src/bbm_datapath.sv
// datapath: config registers, element stores, index divider, address build,
// multiply-accumulate pipeline and output register; depends on bbm_pkg and the macros
`include "batched_broadcast_matmul_macros.svh"
module bbm_datapath import bbm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_W-1:0]        csr_index,
   input  logic [SIDE_W-1:0]       csr_wdata,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [IDX_W-1:0]        req_index,
   input  logic signed [VAL_W-1:0] req_value,
   input  bbm_cmd_type             cmd,
   output bbm_sts_type             sts,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_product,
   output logic [STS_W-1:0]        rsp_status
);

   localparam int MN_W  = $clog2(MAX_MATRIX_SIDE * MAX_MATRIX_SIDE + 1);
   localparam int CC_W  = $clog2(MAX_BATCH * MAX_BATCH + 1);
   localparam int TOT_W = IDX_W + 1;
   localparam int TA_W  = 2 * COORD_W + BATCH_W;

   function automatic logic [BATCH_W-1:0] clamp_batch(input logic [BATCH_W-1:0] v,
                                                      input int dim);
      logic [BATCH_W-1:0] r;
      if (dim >= BATCH_DIMS) r = BATCH_W'(1);
      else if (v == '0) r = BATCH_W'(1);
      else if (v > BATCH_W'(MAX_BATCH)) r = BATCH_W'(MAX_BATCH);
      else r = v;
      return r;
   endfunction

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) r = SIDE_W'(1);
      else if (v > SIDE_W'(MAX_MATRIX_SIDE)) r = SIDE_W'(MAX_MATRIX_SIDE);
      else r = v;
      return r;
   endfunction

   // configuration registers
   logic [BATCH_W-1:0] a_outer_ff, a_inner_ff, b_outer_ff, b_inner_ff;
   logic [SIDE_W-1:0]  rows_m_ff, inner_k_ff, cols_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_outer_ff <= BATCH_W'(1);
         a_inner_ff <= BATCH_W'(1);
         b_outer_ff <= BATCH_W'(1);
         b_inner_ff <= BATCH_W'(1);
         rows_m_ff  <= SIDE_W'(1);
         inner_k_ff <= SIDE_W'(1);
         cols_n_ff  <= SIDE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_A_OUTER: a_outer_ff <= csr_wdata[BATCH_W-1:0];
            CSR_A_INNER: a_inner_ff <= csr_wdata[BATCH_W-1:0];
            CSR_B_OUTER: b_outer_ff <= csr_wdata[BATCH_W-1:0];
            CSR_B_INNER: b_inner_ff <= csr_wdata[BATCH_W-1:0];
            CSR_ROWS_M:  rows_m_ff  <= csr_wdata;
            CSR_INNER_K: inner_k_ff <= csr_wdata;
            CSR_COLS_N:  cols_n_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [BATCH_W-1:0] a0, a1, b0, b1, c0, c1;
   logic [SIDE_W-1:0]  mc, kc, nc;
   logic               batch_bad;

   always_comb begin
      a0 = clamp_batch(a_outer_ff, 0);
      a1 = clamp_batch(a_inner_ff, 1);
      b0 = clamp_batch(b_outer_ff, 0);
      b1 = clamp_batch(b_inner_ff, 1);
      mc = clamp_side(rows_m_ff);
      kc = clamp_side(inner_k_ff);
      nc = clamp_side(cols_n_ff);
      c0 = (a0 > b0) ? a0 : b0;
      c1 = (a1 > b1) ? a1 : b1;
      batch_bad = (a0 != b0 && a0 != BATCH_W'(1) && b0 != BATCH_W'(1)) ||
                  (a1 != b1 && a1 != BATCH_W'(1) && b1 != BATCH_W'(1));
   end

   // element stores
   logic [VAL_W-1:0] mem_a [STORE_DEPTH];
   logic [VAL_W-1:0] mem_b [STORE_DEPTH];
   logic [VAL_W-1:0] rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0] a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;

   always_ff @(posedge clock) begin
      if (cmd.accept && req_kind == KIND_WRITE_A) mem_a[req_index] <= req_value;
      rd_a_ff <= mem_a[a_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_kind == KIND_WRITE_B) mem_b[req_index] <= req_value;
      rd_b_ff <= mem_b[b_addr_ff];
   end

   // item index and shape products
   logic [IDX_W-1:0] idx_ff;
   logic [MN_W-1:0]  mn_ff;
   logic [CC_W-1:0]  cc_ff;
   logic             bad_ff;
   logic [TOT_W-1:0] total;
   logic             oor;
   status_type       res_status_ff;

   assign total = TOT_W'(cc_ff) * TOT_W'(mn_ff);
   assign oor   = {1'b0, idx_ff} >= total;

   always_ff @(posedge clock) begin
      if (cmd.accept) idx_ff <= req_index;
      if (cmd.prep) begin
         mn_ff  <= MN_W'(mc) * MN_W'(nc);
         cc_ff  <= CC_W'(c0) * CC_W'(c1);
         bad_ff <= batch_bad;
      end
      if (cmd.check) begin
         if (bad_ff) res_status_ff <= STATUS_BAD_BATCH;
         else if (oor) res_status_ff <= STATUS_OUT_OF_RANGE;
         else res_status_ff <= STATUS_OK;
      end
   end

   // shared restoring divider, one quotient bit per step
   logic [POS_W-1:0]   div_rem_ff;
   logic [IDX_W-1:0]   div_quo_ff;
   logic [SIDE_W-1:0]  divisor;
   logic [POS_W:0]     trial;
   logic [POS_W-1:0]   col_ff, row_ff;
   logic [COORD_W-1:0] o0_ff, o1_ff;

   always_comb begin
      unique case (cmd.div_phase)
         DIV_COL:   divisor = nc;
         DIV_ROW:   divisor = mc;
         DIV_BATCH: divisor = SIDE_W'(c1);
         default:   divisor = nc;
      endcase
      trial = {div_rem_ff, div_quo_ff[IDX_W-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_rem_ff <= '0;
         div_quo_ff <= idx_ff;
      end else if (cmd.div_step) begin
         if (SIDE_W'(trial) >= divisor) begin
            div_rem_ff <= POS_W'(SIDE_W'(trial) - divisor);
            div_quo_ff <= {div_quo_ff[IDX_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= trial[POS_W-1:0];
            div_quo_ff <= {div_quo_ff[IDX_W-2:0], 1'b0};
         end
      end else if (cmd.div_capture) begin
         // quotient stays in place as the next dividend
         div_rem_ff <= '0;
         unique case (cmd.div_phase)
            DIV_COL:   col_ff <= div_rem_ff;
            DIV_ROW:   row_ff <= div_rem_ff;
            DIV_BATCH: begin
               o1_ff <= div_rem_ff[COORD_W-1:0];
               o0_ff <= div_quo_ff[COORD_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // address build and multiply-accumulate pipeline
   logic [COORD_W-1:0] ia0, ia1, ib0, ib1;
   logic [TA_W-1:0]    ta, tb;
   logic [VAL_W-1:0]   prod_ff, acc_ff;
   logic               rd_vld_ff, prod_vld_ff;

   always_comb begin
      ia0 = (a0 == c0) ? o0_ff : '0;
      ia1 = (a1 == c1) ? o1_ff : '0;
      ib0 = (b0 == c0) ? o0_ff : '0;
      ib1 = (b1 == c1) ? o1_ff : '0;
      ta  = TA_W'(ia0) * TA_W'(a1) + TA_W'(ia1);
      tb  = TA_W'(ib0) * TA_W'(b1) + TA_W'(ib1);
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      if (cmd.adr0) begin
         a_addr_in = IDX_W'(ta);
         b_addr_in = IDX_W'(tb);
      end else if (cmd.adr1) begin
         a_addr_in = a_addr_ff * IDX_W'(mc) + IDX_W'(row_ff);
         b_addr_in = b_addr_ff * IDX_W'(kc);
      end else if (cmd.adr2) begin
         a_addr_in = a_addr_ff * IDX_W'(kc);
         b_addr_in = b_addr_ff * IDX_W'(nc) + IDX_W'(col_ff);
      end else if (cmd.mac_issue) begin
         // addresses wrap at the store depth
         a_addr_in = a_addr_ff + IDX_W'(1);
         b_addr_in = b_addr_ff + IDX_W'(nc);
      end
   end

   always_ff @(posedge clock) begin
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      prod_ff   <= rd_a_ff * rd_b_ff;
      if (cmd.adr2) acc_ff <= '0;
      else if (prod_vld_ff) acc_ff <= acc_ff + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.mac_issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // output register
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_product_ff;
   status_type              rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_product_ff <= (res_status_ff == STATUS_OK) ? acc_ff : '0;
         rsp_status_ff  <= res_status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = rsp_product_ff;
   assign rsp_status  = rsp_status_ff;

   always_comb begin
      sts.bad_batch    = bad_ff;
      sts.out_of_range = oor;
      sts.k_last       = CNT_W'(kc - SIDE_W'(1));
      sts.pipe_busy    = rd_vld_ff || prod_vld_ff;
      sts.out_full     = rsp_valid_ff && !rsp_ready;
   end

   `BBM_ASSERT_NEXT(a_div_rem_below, clock, reset, cmd.div_step, div_rem_ff < $past(divisor), "divider remainder not below divisor")
   `BBM_ASSERT_IMP(a_div_only_valid, clock, reset, cmd.div_init, !bad_ff && !oor, "index decomposition started on a failed item")

endmodule

>>> src/bbm_ctrl.sv
// controller state machine: sequences check, index division, address build,
// multiply-accumulate and result load; depends on bbm_pkg and the macros
`include "batched_broadcast_matmul_macros.svh"
module bbm_ctrl import bbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   input  bbm_sts_type       sts,
   output bbm_cmd_type       cmd
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_PREP     = 11'b000_0000_0010,
      ST_CHECK    = 11'b000_0000_0100,
      ST_DIV      = 11'b000_0000_1000,
      ST_DIV_NEXT = 11'b000_0001_0000,
      ST_ADR0     = 11'b000_0010_0000,
      ST_ADR1     = 11'b000_0100_0000,
      ST_ADR2     = 11'b000_1000_0000,
      ST_MAC      = 11'b001_0000_0000,
      ST_DRAIN    = 11'b010_0000_0000,
      ST_RESULT   = 11'b100_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   div_phase_type    phase_ff, phase_in;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      phase_in      = phase_ff;
      cmd           = '0;
      cmd.div_phase = phase_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_kind == KIND_COMPUTE) state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.bad_batch || sts.out_of_range) begin
               state_in = ST_RESULT;
            end else begin
               cmd.div_init = 1'b1;
               phase_in     = DIV_COL;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV_NEXT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIV_NEXT: begin
            cmd.div_capture = 1'b1;
            if (phase_ff == DIV_BATCH) begin
               state_in = ST_ADR0;
            end else begin
               phase_in = (phase_ff == DIV_COL) ? DIV_ROW : DIV_BATCH;
               state_in = ST_DIV;
            end
         end
         ST_ADR0: begin
            cmd.adr0 = 1'b1;
            state_in = ST_ADR1;
         end
         ST_ADR1: begin
            cmd.adr1 = 1'b1;
            state_in = ST_ADR2;
         end
         ST_ADR2: begin
            cmd.adr2 = 1'b1;
            cnt_in   = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (cnt_ff == sts.k_last) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // wait for the output register to free up
            if (!sts.out_full) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         phase_ff <= DIV_COL;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

   `BBM_ASSERT_IMP(a_load_when_free, clock, reset, cmd.rsp_load, !sts.out_full, "result loaded into an occupied output register")
   `BBM_ASSERT_NEXT(a_compute_starts, clock, reset, cmd.accept && req_kind == KIND_COMPUTE, state_ff == ST_PREP, "accepted compute transaction did not start")

endmodule

>>> test/batched_broadcast_matmul_test.sv
// self-checking testbench for batched_broadcast_matmul: loads both element stores,
// asks for broadcast output elements and checks every result against its own model
// depends on bbm_pkg, bbm_req_if, bbm_rsp_if and the batched_broadcast_matmul rtl
module batched_broadcast_matmul_test;
   import bbm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 1400;
   localparam int SETTLE_CYCLES  = 72;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic [VAL_W-1:0] value;
      status_type       sts;
   } product_type;

   typedef enum {DRAIN_FREE, DRAIN_RANDOM, DRAIN_SLOW, DRAIN_PERIODIC} drain_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_index;
   logic [SIDE_W-1:0] csr_wdata;

   bbm_req_if req_chan();
   bbm_rsp_if rsp_chan();

   batched_broadcast_matmul u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // mirror of the block: element stores, written flags and shape registers
   logic [VAL_W-1:0]  a_image [STORE_DEPTH];
   logic [VAL_W-1:0]  b_image [STORE_DEPTH];
   bit                a_loaded [STORE_DEPTH];
   bit                b_loaded [STORE_DEPTH];
   logic [SIDE_W-1:0] shape_reg [7];

   product_type pending_products[$];
   int error_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   int stall_left  = 0;
   drain_mode_type drain_mode = DRAIN_FREE;

   function automatic int unsigned saturate(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void get_dims(output int unsigned a0, a1, b0, b1, m, k, n);
      a0 = (BATCH_DIMS > 0) ? saturate(shape_reg[CSR_A_OUTER], MAX_BATCH) : 1;
      a1 = (BATCH_DIMS > 1) ? saturate(shape_reg[CSR_A_INNER], MAX_BATCH) : 1;
      b0 = (BATCH_DIMS > 0) ? saturate(shape_reg[CSR_B_OUTER], MAX_BATCH) : 1;
      b1 = (BATCH_DIMS > 1) ? saturate(shape_reg[CSR_B_INNER], MAX_BATCH) : 1;
      m  = saturate(shape_reg[CSR_ROWS_M], MAX_MATRIX_SIDE);
      k  = saturate(shape_reg[CSR_INNER_K], MAX_MATRIX_SIDE);
      n  = saturate(shape_reg[CSR_COLS_N], MAX_MATRIX_SIDE);
   endfunction

   function automatic int unsigned output_size();
      int unsigned a0, a1, b0, b1, m, k, n;
      get_dims(a0, a1, b0, b1, m, k, n);
      return (a0 > b0 ? a0 : b0) * (a1 > b1 ? a1 : b1) * m * n;
   endfunction

   // status of an output element and the store addresses its dot product reads
   function automatic status_type locate_operands(input logic [IDX_W-1:0] idx,
                                                  output int unsigned a_addr[MAX_MATRIX_SIDE],
                                                  output int unsigned b_addr[MAX_MATRIX_SIDE],
                                                  output int unsigned depth_k);
      int unsigned a0, a1, b0, b1, m, k, n, c0, c1;
      int unsigned col, row, o0, o1, ia0, ia1, ib0, ib1, abase;
      get_dims(a0, a1, b0, b1, m, k, n);
      depth_k = k;
      if ((a0 != b0 && a0 != 1 && b0 != 1) || (a1 != b1 && a1 != 1 && b1 != 1))
         return STATUS_BAD_BATCH;
      c0 = a0 > b0 ? a0 : b0;
      c1 = a1 > b1 ? a1 : b1;
      if (idx >= c0 * c1 * m * n)
         return STATUS_OUT_OF_RANGE;
      col = idx % n;
      row = (idx / n) % m;
      o1  = (idx / (n * m)) % c1;
      o0  = idx / (n * m * c1);
      ia0 = (a0 == c0) ? o0 : 0;
      ia1 = (a1 == c1) ? o1 : 0;
      ib0 = (b0 == c0) ? o0 : 0;
      ib1 = (b1 == c1) ? o1 : 0;
      abase = ((ia0 * a1 + ia1) * m + row) * k;
      for (int kk = 0; kk < k; kk++) begin
         a_addr[kk] = (abase + kk) % STORE_DEPTH;
         b_addr[kk] = (((ib0 * b1 + ib1) * k + kk) * n + col) % STORE_DEPTH;
      end
      return STATUS_OK;
   endfunction

   function automatic product_type predict_product(logic [IDX_W-1:0] idx);
      product_type result;
      int unsigned a_addr[MAX_MATRIX_SIDE];
      int unsigned b_addr[MAX_MATRIX_SIDE];
      int unsigned k;
      result.sts   = locate_operands(idx, a_addr, b_addr, k);
      result.value = '0;
      if (result.sts == STATUS_OK)
         for (int kk = 0; kk < k; kk++)
            result.value = result.value + a_image[a_addr[kk]] * b_image[b_addr[kk]];
      return result;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // one request transaction; called and returns at a falling edge
   task automatic send_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                            logic [VAL_W-1:0] value);
      if (burst_left == 0) begin
         if ($urandom_range(3) != 0)
            repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(7) == 0) ? 64 : $urandom_range(1, 16);
      end
      req_chan.valid         = 1'b1;
      req_chan.kind          = kind;
      req_chan.element_index = idx;
      req_chan.write_value   = value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      case (kind)
         KIND_WRITE_A: begin
            a_image[idx]  = value;
            a_loaded[idx] = 1'b1;
         end
         KIND_WRITE_B: begin
            b_image[idx]  = value;
            b_loaded[idx] = 1'b1;
         end
         KIND_COMPUTE: pending_products.push_back(predict_product(idx));
         default: ;
      endcase
      if (kind != KIND_UNUSED) items_sent++;
      burst_left--;
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   // loads any operand not yet written, then asks for the element
   task automatic send_compute(logic [IDX_W-1:0] idx);
      int unsigned a_addr[MAX_MATRIX_SIDE];
      int unsigned b_addr[MAX_MATRIX_SIDE];
      int unsigned k;
      status_type  sts;
      sts = locate_operands(idx, a_addr, b_addr, k);
      if (sts == STATUS_OK) begin
         for (int kk = 0; kk < k; kk++) begin
            if (!a_loaded[a_addr[kk]])
               send_item(KIND_WRITE_A, IDX_W'(a_addr[kk]), pick_value());
            if (!b_loaded[b_addr[kk]])
               send_item(KIND_WRITE_B, IDX_W'(b_addr[kk]), pick_value());
         end
      end
      send_item(KIND_COMPUTE, idx, $urandom);
   endtask

   task automatic wait_results();
      while (pending_products.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [SIDE_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx <= CSR_B_INNER)
         shape_reg[idx] = value & SIDE_W'((1 << BATCH_W) - 1);
      else
         shape_reg[idx] = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // registers change only with the block idle
   task automatic set_shape(int unsigned a0, a1, b0, b1, m, k, n);
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_register(CSR_A_OUTER, SIDE_W'(a0));
      write_register(CSR_A_INNER, SIDE_W'(a1));
      write_register(CSR_B_OUTER, SIDE_W'(b0));
      write_register(CSR_B_INNER, SIDE_W'(b1));
      write_register(CSR_ROWS_M, SIDE_W'(m));
      write_register(CSR_INNER_K, SIDE_W'(k));
      write_register(CSR_COLS_N, SIDE_W'(n));
   endtask

   task automatic test_reset_shape();
      send_item(KIND_WRITE_A, 0, 32'h7fff_ffff);
      send_item(KIND_WRITE_B, 0, 32'h8000_0000);
      send_compute(0);
      // the unused kind must leave A[0] alone
      send_item(KIND_UNUSED, 0, '1);
      send_compute(0);
      send_compute(1);
      send_compute(IDX_W'(STORE_DEPTH - 1));
      send_item(KIND_WRITE_A, IDX_W'(STORE_DEPTH - 1), '0);
      send_item(KIND_WRITE_B, IDX_W'(STORE_DEPTH - 1), '1);
   endtask

   task automatic test_saturated_shape();
      // zero and oversize registers saturate: 1x4 against 4x1, 16x1 times 1x16
      set_shape(0, 7, 7, 0, 31, 0, 17);
      send_compute(IDX_W'(STORE_DEPTH - 1));
      send_compute(0);
      send_compute(2048);
      send_compute(1234);
   endtask

   task automatic test_batch_mismatch();
      set_shape(2, 1, 3, 1, 2, 2, 2);
      send_compute(0);
      send_compute(IDX_W'(STORE_DEPTH - 1));
      set_shape(1, 3, 1, 2, 1, 3, 1);
      send_compute(0);
   endtask

   function automatic logic [SIDE_W-1:0] pick_batch(int unsigned common);
      int unsigned r;
      r = $urandom_range(9);
      if (r < 6) return SIDE_W'(common);
      if (r < 9) return SIDE_W'(1);
      return SIDE_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [SIDE_W-1:0] pick_side();
      if ($urandom_range(3) == 0) return SIDE_W'($urandom_range(0, 31));
      return SIDE_W'($urandom_range(1, 4));
   endfunction

   task automatic test_random_traffic();
      int unsigned c0, c1, r, phase_end;
      int phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase % 4 == 3) begin
            set_shape(4, 4, 4, 4, 16, 16, 16);
            phase_end = items_sent + 40;
         end else begin
            c0 = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 2);
            c1 = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 2);
            set_shape(pick_batch(c0), pick_batch(c1), pick_batch(c0), pick_batch(c1),
                      pick_side(), pick_side(), pick_side());
            phase_end = items_sent + 130;
         end
         phase++;
         while (items_sent < phase_end) begin
            r = $urandom_range(99);
            if (r < 65)
               send_compute(IDX_W'($urandom_range(output_size() - 1)));
            else if (r < 80)
               send_item($urandom_range(1) ? KIND_WRITE_A : KIND_WRITE_B, IDX_W'($urandom),
                         pick_value());
            else if (r < 88)
               send_compute(IDX_W'($urandom));
            else if (r < 93)
               send_item(KIND_UNUSED, IDX_W'($urandom), $urandom);
            else if (r < 95)
               wait_results();
            else
               send_compute(IDX_W'($urandom_range(output_size() - 1)));
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      product_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_products.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual value %h status %0d",
                     $time, rsp_chan.product_value, rsp_chan.status);
         end else begin
            want = pending_products.pop_front();
            if (rsp_chan.product_value !== want.value) begin
               error_count++;
               $display("%0t: product_value mismatch: expected %h, actual %h",
                        $time, want.value, rsp_chan.product_value);
            end
            if (rsp_chan.status !== want.sts) begin
               error_count++;
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.sts, rsp_chan.status);
            end
         end
      end
   end

   // result side backpressure, a pattern independent of the sender
   always @(negedge clock) begin
      if (stall_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(3));
         stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      case (drain_mode)
         DRAIN_FREE:   rsp_chan.ready = 1'b1;
         DRAIN_RANDOM: rsp_chan.ready = 1'($urandom_range(1));
         DRAIN_SLOW:   rsp_chan.ready = ($urandom_range(3) == 0);
         default:      rsp_chan.ready = (stall_left % 24) < 16;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid         = 1'b0;
      req_chan.kind          = KIND_WRITE_A;
      req_chan.element_index = '0;
      req_chan.write_value   = '0;
      rsp_chan.ready         = 1'b0;
      csr_we                 = 1'b0;
      csr_index              = CSR_A_OUTER;
      csr_wdata              = '0;
      foreach (shape_reg[i]) shape_reg[i] = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_shape();
      test_saturated_shape();
      test_batch_mismatch();
      test_random_traffic();

      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_products.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
